// ===== src/itd_pkg.sv =====
// Shared types and constants for the inspiration trigger detector.
// Holds the configuration record, the sensitivity codes and the fixed
// interpolation and reciprocal constants. Depends on nothing.
package itd_pkg;

	localparam int FLOW_W     = 16;
	localparam int TIME_W     = 16;
	localparam int VOL_W      = 16;
	localparam int PEEP_W     = 10;
	localparam int LOCK_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Volume breakpoints of the lockout interpolation.
	localparam logic [VOL_W-1:0] VOL_ADULT_LO = 16'd250;
	localparam logic [VOL_W-1:0] VOL_ADULT_HI = 16'd1900;
	localparam logic [VOL_W-1:0] VOL_CHILD_LO = 16'd50;
	localparam int               SPAN_W       = 11;
	localparam logic [SPAN_W-1:0] ADULT_SPAN  = 11'd1650;
	localparam logic [SPAN_W-1:0] CHILD_SPAN  = 11'd200;

	localparam logic [PEEP_W-1:0] PEEP_LIMIT   = 10'd140;
	localparam logic [LOCK_W-1:0] LOCKOUT_L0P  = 16'd300;
	localparam logic [LOCK_W-1:0] LOCKOUT_L1P  = 16'd500;

	// x/3 for x below 2^17 is exactly (x * 43691) >> 17.
	localparam int                RECIP3_W     = 16;
	localparam logic [RECIP3_W-1:0] RECIP3     = 16'd43691;
	localparam int                RECIP3_SHIFT = 17;

	// t/750 for any 16-bit t is exactly (t * 89479) >> 26.
	localparam int                 RECIP750_W     = 17;
	localparam logic [RECIP750_W-1:0] RECIP750    = 17'd89479;
	localparam int                 RECIP750_SHIFT = 26;
	localparam int                 ELAPSED_W      = 7;

	localparam int PROD_W = 29;

	typedef enum logic [2:0] {
		SENS_OFF   = 3'd0,
		SENS_L0P   = 3'd1,
		SENS_L1P   = 3'd2,
		SENS_L2    = 3'd3,
		SENS_L3    = 3'd4,
		SENS_L4    = 3'd5,
		SENS_L5    = 3'd6,
		SENS_OTHER = 3'd7
	} sens_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENS      = 3'd0,
		CFG_PEEP      = 3'd1,
		CFG_ADULT_MIN = 3'd2,
		CFG_ADULT_MAX = 3'd3,
		CFG_CHILD_MIN = 3'd4,
		CFG_CHILD_MAX = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		sens_t              sens;
		logic [PEEP_W-1:0]  peep;
		logic [LOCK_W-1:0]  adult_min;
		logic [LOCK_W-1:0]  adult_max;
		logic [LOCK_W-1:0]  child_min;
		logic [LOCK_W-1:0]  child_max;
	} cfg_t;

	// Timing terms formed in the first stage and judged in the second.
	typedef struct packed {
		logic signed [PROD_W-1:0] prod_vol;
		logic signed [PROD_W-1:0] prod_time;
		logic                     adult;
		logic                     fixed_sel;
		logic                     fixed_ok;
		logic [ELAPSED_W-1:0]     elapsed;
	} time_terms_t;

endpackage

// ===== src/itd_cfg.sv =====
// Configuration register file of the inspiration trigger detector.
// Depends on itd_pkg for the register record and index codes.
module itd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [itd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [itd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output itd_pkg::cfg_t                     cfg
);

	itd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sens      <= itd_pkg::SENS_OFF;
			cfg_q.peep      <= 10'd50;
			cfg_q.adult_min <= 16'd300;
			cfg_q.adult_max <= 16'd1000;
			cfg_q.child_min <= 16'd300;
			cfg_q.child_max <= 16'd600;
		end else if (cfg_valid) begin
			// Indexes beyond the list are ignored.
			unique case (itd_pkg::cfg_idx_t'(cfg_index))
				itd_pkg::CFG_SENS:      cfg_q.sens      <= itd_pkg::sens_t'(cfg_data[2:0]);
				itd_pkg::CFG_PEEP:      cfg_q.peep      <= cfg_data[itd_pkg::PEEP_W-1:0];
				itd_pkg::CFG_ADULT_MIN: cfg_q.adult_min <= cfg_data;
				itd_pkg::CFG_ADULT_MAX: cfg_q.adult_max <= cfg_data;
				itd_pkg::CFG_CHILD_MIN: cfg_q.child_min <= cfg_data;
				itd_pkg::CFG_CHILD_MAX: cfg_q.child_max <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/itd_filter.sv =====
// Flow filter of the inspiration trigger detector: holds the flow history
// and phase bit, forms the filtered flow and the rise against the history.
// Depends on itd_pkg for widths and the divide-by-three reciprocal.
module itd_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic signed [itd_pkg::FLOW_W-1:0]  flow,
	output logic signed [itd_pkg::FLOW_W-1:0]  delta,
	output logic                               compute
);

	localparam int SUM_W  = itd_pkg::FLOW_W + 2;
	localparam int MAG_W  = SUM_W - 1;
	localparam int MUL_W  = MAG_W + itd_pkg::RECIP3_W;

	logic signed [itd_pkg::FLOW_W-1:0] hist_q;
	logic                              phase_q;
	logic signed [SUM_W-1:0]           sum;
	logic                              neg;
	logic [MAG_W-1:0]                  mag;
	logic [MUL_W-1:0]                  prod;
	logic [itd_pkg::FLOW_W-1:0]        quot;
	logic signed [itd_pkg::FLOW_W-1:0] filt;

	always_comb begin
		sum  = SUM_W'(flow) + (SUM_W'(hist_q) <<< 1);
		neg  = sum[SUM_W-1];
		mag  = neg ? MAG_W'(-sum) : MAG_W'(sum);
		prod = MUL_W'(mag) * MUL_W'(itd_pkg::RECIP3);
		quot = prod[itd_pkg::RECIP3_SHIFT +: itd_pkg::FLOW_W];
		// Division by three truncates toward zero, so negate the magnitude quotient.
		filt = neg ? itd_pkg::FLOW_W'(-quot) : quot;
	end

	assign delta   = filt - hist_q;
	assign compute = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			phase_q <= 1'b0;
		end else if (advance) begin
			phase_q <= ~phase_q;
			if (phase_q) begin
				hist_q <= filt;
			end
		end
	end

endmodule

// ===== src/itd_timing.sv =====
// Timing terms of the inspiration trigger detector: the interpolated
// lockout, reduced to two products for a division-free compare, the
// elapsed time over 750 and the fixed lockouts. Depends on itd_pkg.
module itd_timing (
	input  itd_pkg::cfg_t                    cfg,
	input  logic [itd_pkg::TIME_W-1:0]       expiration_time,
	input  logic [itd_pkg::VOL_W-1:0]        inspired_volume,
	output itd_pkg::time_terms_t             terms
);

	localparam int DIFF_W = itd_pkg::LOCK_W + 1;
	localparam int TQ_W   = itd_pkg::TIME_W + itd_pkg::RECIP750_W;

	logic                               adult;
	logic [itd_pkg::VOL_W-1:0]          vol_c;
	logic [itd_pkg::SPAN_W-1:0]         x_off;
	logic [itd_pkg::SPAN_W-1:0]         span;
	logic [itd_pkg::LOCK_W-1:0]         lo_val;
	logic [itd_pkg::LOCK_W-1:0]         hi_val;
	logic signed [DIFF_W-1:0]           rise;
	logic signed [DIFF_W-1:0]           t_off;
	logic [TQ_W-1:0]                    tq;

	always_comb begin
		adult = inspired_volume >= itd_pkg::VOL_ADULT_LO;
		if (adult) begin
			vol_c  = (inspired_volume > itd_pkg::VOL_ADULT_HI) ?
			         itd_pkg::VOL_ADULT_HI : inspired_volume;
			x_off  = itd_pkg::SPAN_W'(vol_c - itd_pkg::VOL_ADULT_LO);
			span   = itd_pkg::ADULT_SPAN;
			lo_val = cfg.adult_min;
			hi_val = cfg.adult_max;
		end else begin
			vol_c  = (inspired_volume < itd_pkg::VOL_CHILD_LO) ?
			         itd_pkg::VOL_CHILD_LO : inspired_volume;
			x_off  = itd_pkg::SPAN_W'(vol_c - itd_pkg::VOL_CHILD_LO);
			span   = itd_pkg::CHILD_SPAN;
			lo_val = cfg.child_min;
			hi_val = cfg.child_max;
		end
		rise  = DIFF_W'(hi_val) - DIFF_W'(lo_val);
		t_off = DIFF_W'(expiration_time) - DIFF_W'(lo_val);

		// The lockout test te >= lo + trunc(x*rise/span) becomes a compare of
		// x*rise against (te - lo)*span in the next stage.
		terms.prod_vol  = itd_pkg::PROD_W'($signed({1'b0, x_off})) *
		                  itd_pkg::PROD_W'(rise);
		terms.prod_time = itd_pkg::PROD_W'(t_off) *
		                  itd_pkg::PROD_W'($signed({1'b0, span}));
		terms.adult     = adult;

		tq = TQ_W'(expiration_time) * TQ_W'(itd_pkg::RECIP750);
		terms.elapsed = tq[itd_pkg::RECIP750_SHIFT +: itd_pkg::ELAPSED_W];

		unique case (cfg.sens)
			itd_pkg::SENS_L0P: begin
				terms.fixed_sel = 1'b1;
				terms.fixed_ok  = expiration_time >= itd_pkg::LOCKOUT_L0P;
			end
			itd_pkg::SENS_L1P: begin
				terms.fixed_sel = 1'b1;
				terms.fixed_ok  = expiration_time >= itd_pkg::LOCKOUT_L1P;
			end
			default: begin
				terms.fixed_sel = 1'b0;
				terms.fixed_ok  = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/inspiration_trigger_detect.sv =====
// Top level of the inspiration trigger detector.
// Instantiates itd_cfg, itd_filter and itd_timing; depends on itd_pkg.
//
// Usage: flow samples enter on the sample channel (sample_valid with
// measured_flow, expiration_time, inspired_volume; the block drives
// sample_stall). Every sample gives exactly one item on the result channel
// (result_valid with trigger_detected; the receiver drives result_stall).
// Registers are written through cfg_valid, cfg_index and cfg_data while the
// block is idle; cfg_ready is always high.
// The datapath is an input register, a stage register behind the filter and
// timing logic, and a result register behind the trigger compare. A new sample
// is taken every cycle while sample_stall is low; the loop from the flow history
// register through the divide-by-three multiplier back into it allows that rate.
// Reset clears the pipeline, the flow history and the phase bit, and loads
// the register defaults. When the receiver stalls, the result register holds
// and the stages behind it keep filling until each holds an item; only then
// is sample_stall raised, and it falls as soon as the result is taken.
module inspiration_trigger_detect (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [itd_pkg::FLOW_W-1:0]   measured_flow,
	input  logic [itd_pkg::TIME_W-1:0]          expiration_time,
	input  logic [itd_pkg::VOL_W-1:0]           inspired_volume,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                trigger_detected,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [itd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [itd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CMP_W = itd_pkg::FLOW_W + 2;
	localparam int THR_W = 5;

	itd_pkg::cfg_t cfg;

	logic                              valid_s1;
	logic signed [itd_pkg::FLOW_W-1:0] flow_s1;
	logic [itd_pkg::TIME_W-1:0]        te_s1;
	logic [itd_pkg::VOL_W-1:0]         vol_s1;

	logic                              valid_s2;
	logic signed [itd_pkg::FLOW_W-1:0] delta_s2;
	logic                              compute_s2;
	itd_pkg::time_terms_t              terms_s2;

	logic                              valid_q;
	logic                              trig_q;

	logic                              rdy_out;
	logic                              rdy_2;
	logic                              rdy_1;
	logic                              adv1;
	logic                              adv2;

	logic signed [itd_pkg::FLOW_W-1:0] delta;
	logic                              compute;
	itd_pkg::time_terms_t              terms;

	logic [THR_W-1:0]                  thr;
	logic [THR_W-1:0]                  margin;
	logic                              low_peep;
	logic signed [CMP_W-1:0]           delta_x;
	logic signed [CMP_W-1:0]           bound_time;
	logic signed [CMP_W-1:0]           bound_margin;
	logic signed [itd_pkg::PROD_W:0]   time_hi;
	logic                              lock_ok;
	logic                              trig;

	assign cfg_ready = 1'b1;

	itd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Each stage moves when the one ahead of it is empty or moving.
	assign rdy_out      = !valid_q || !result_stall;
	assign rdy_2        = !valid_s2 || rdy_out;
	assign rdy_1        = !valid_s1 || rdy_2;
	assign adv1         = valid_s1 && rdy_2;
	assign adv2         = valid_s2 && rdy_out;
	assign sample_stall = !rdy_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && rdy_1) begin
			flow_s1 <= measured_flow;
			te_s1   <= expiration_time;
			vol_s1  <= inspired_volume;
		end
	end

	itd_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv1),
		.flow    (flow_s1),
		.delta   (delta),
		.compute (compute)
	);

	itd_timing u_timing (
		.cfg             (cfg),
		.expiration_time (te_s1),
		.inspired_volume (vol_s1),
		.terms           (terms)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			delta_s2   <= delta;
			compute_s2 <= compute;
			terms_s2   <= terms;
		end
	end

	// Threshold and margin from the sensitivity level and the PEEP band.
	always_comb begin
		low_peep = cfg.peep <= itd_pkg::PEEP_LIMIT;
		margin   = 5'd4;
		unique case (cfg.sens)
			itd_pkg::SENS_L0P: begin
				thr    = 5'd6;
				margin = 5'd2;
			end
			itd_pkg::SENS_L1P: thr = 5'd8;
			itd_pkg::SENS_L2:  thr = low_peep ? 5'd11 : 5'd13;
			itd_pkg::SENS_L3:  thr = low_peep ? 5'd13 : 5'd15;
			itd_pkg::SENS_L4:  thr = low_peep ? 5'd14 : 5'd16;
			itd_pkg::SENS_L5:  thr = low_peep ? 5'd16 : 5'd18;
			itd_pkg::SENS_OFF,
			itd_pkg::SENS_OTHER: thr = 5'd11;
			default: thr = 5'd11;
		endcase
	end

	always_comb begin
		delta_x      = CMP_W'(delta_s2);
		bound_time   = CMP_W'(thr) - CMP_W'(terms_s2.elapsed);
		bound_margin = CMP_W'(thr) - CMP_W'(margin);

		// A positive quotient truncates down, a negative one up, so the
		// strict and non-strict forms of the product compare differ.
		time_hi = (itd_pkg::PROD_W + 1)'(terms_s2.prod_time) +
		          (terms_s2.adult ? (itd_pkg::PROD_W + 1)'(itd_pkg::ADULT_SPAN) :
		                            (itd_pkg::PROD_W + 1)'(itd_pkg::CHILD_SPAN));
		if (terms_s2.fixed_sel) begin
			lock_ok = terms_s2.fixed_ok;
		end else if (terms_s2.prod_vol[itd_pkg::PROD_W-1]) begin
			lock_ok = terms_s2.prod_vol <= terms_s2.prod_time;
		end else begin
			lock_ok = (itd_pkg::PROD_W + 1)'(terms_s2.prod_vol) < time_hi;
		end

		trig = compute_s2 && (cfg.sens != itd_pkg::SENS_OFF) && lock_ok &&
		       (delta_x >= bound_time) && (delta_x >= bound_margin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy_out) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			trig_q <= trig;
		end
	end

	assign result_valid     = valid_q;
	assign trigger_detected = trig_q;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the inspiration trigger detector.
// Predicts each trigger flag from its own copy of the filter, phase and register
// state, and compares it in order. Depends on itd_pkg and inspiration_trigger_detect.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FILTER_DIV      = 3;
	localparam int TIME_DIV        = 750;
	localparam int LATENCY         = 3;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int PHASES          = 8;
	localparam logic [itd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [itd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	logic                               clk;
	logic                               arst_n;
	logic                               sample_valid;
	logic                               sample_stall;
	logic signed [itd_pkg::FLOW_W-1:0]  measured_flow;
	logic [itd_pkg::TIME_W-1:0]         expiration_time;
	logic [itd_pkg::VOL_W-1:0]          inspired_volume;
	logic                               result_valid;
	logic                               result_stall;
	logic                               trigger_detected;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [itd_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [itd_pkg::CFG_DATA_W-1:0]     cfg_data;

	// Predictor state and register copies.
	itd_pkg::sens_t                     sens_m;
	logic [itd_pkg::PEEP_W-1:0]         peep_m;
	logic [itd_pkg::LOCK_W-1:0]         adult_min_m;
	logic [itd_pkg::LOCK_W-1:0]         adult_max_m;
	logic [itd_pkg::LOCK_W-1:0]         child_min_m;
	logic [itd_pkg::LOCK_W-1:0]         child_max_m;
	logic signed [itd_pkg::FLOW_W-1:0]  hist_m;
	logic                               phase_m;

	logic                               pending_triggers[$];
	int                                 error_count;
	int                                 idle_pct;
	int                                 stall_pct;

	inspiration_trigger_detect DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.measured_flow    (measured_flow),
		.expiration_time  (expiration_time),
		.inspired_volume  (inspired_volume),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.trigger_detected (trigger_detected),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("inspiration_trigger_detect test failed");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		logic want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_triggers.size() == 0) begin
				$error("trigger_detected: no item expected, actual %0b", trigger_detected);
				error_count++;
			end else begin
				want = pending_triggers.pop_front();
				if (trigger_detected !== want) begin
					$error("trigger_detected: expected %0b, actual %0b", want,
						trigger_detected);
					error_count++;
				end
			end
		end
	end

	function automatic logic compute_trigger(logic signed [itd_pkg::FLOW_W-1:0] flow,
			logic [itd_pkg::TIME_W-1:0] te, logic [itd_pkg::VOL_W-1:0] vol);
		int     filt;
		int     delta;
		int     thr;
		int     margin;
		int     te_div;
		longint v;
		longint lock;
		logic   low_peep;
		logic   hit;
		low_peep = (peep_m <= itd_pkg::PEEP_LIMIT);
		filt = (int'(flow) + 2 * int'(hist_m)) / FILTER_DIV;
		v = longint'(vol);
		if (vol >= itd_pkg::VOL_ADULT_LO) begin
			if (v > longint'(itd_pkg::VOL_ADULT_HI))
				v = longint'(itd_pkg::VOL_ADULT_HI);
			lock = longint'(adult_min_m) + ((v - longint'(itd_pkg::VOL_ADULT_LO)) *
				(longint'(adult_max_m) - longint'(adult_min_m))) /
				longint'(itd_pkg::ADULT_SPAN);
		end else begin
			if (v < longint'(itd_pkg::VOL_CHILD_LO))
				v = longint'(itd_pkg::VOL_CHILD_LO);
			lock = longint'(child_min_m) + ((v - longint'(itd_pkg::VOL_CHILD_LO)) *
				(longint'(child_max_m) - longint'(child_min_m))) /
				longint'(itd_pkg::CHILD_SPAN);
		end
		margin = 4;
		case (sens_m)
			itd_pkg::SENS_L0P: begin
				lock = longint'(itd_pkg::LOCKOUT_L0P);
				thr = 6;
				margin = 2;
			end
			itd_pkg::SENS_L1P: begin
				lock = longint'(itd_pkg::LOCKOUT_L1P);
				thr = 8;
			end
			itd_pkg::SENS_L2: thr = low_peep ? 11 : 13;
			itd_pkg::SENS_L3: thr = low_peep ? 13 : 15;
			itd_pkg::SENS_L4: thr = low_peep ? 14 : 16;
			itd_pkg::SENS_L5: thr = low_peep ? 16 : 18;
			default: thr = 11;
		endcase
		hit = 1'b0;
		if (phase_m) begin
			// The rise is taken modulo 16 bits before it is compared.
			delta = int'($signed(16'(filt - int'(hist_m))));
			te_div = int'(te) / TIME_DIV;
			phase_m = 1'b0;
			hist_m = 16'(filt);
			hit = (delta >= thr - te_div) && (delta >= thr - margin) &&
				(longint'(te) >= lock);
		end else begin
			phase_m = 1'b1;
		end
		if (sens_m == itd_pkg::SENS_OFF)
			hit = 1'b0;
		return hit;
	endfunction

	// A flow value a given distance above the current filtered history.
	function automatic logic signed [itd_pkg::FLOW_W-1:0] rise_flow(int offset);
		int f;
		f = int'(hist_m) + offset;
		if (f > 32767)
			f = 32767;
		if (f < -32768)
			f = -32768;
		return 16'(f);
	endfunction

	task automatic send_sample(logic signed [itd_pkg::FLOW_W-1:0] flow,
			logic [itd_pkg::TIME_W-1:0] te, logic [itd_pkg::VOL_W-1:0] vol);
		if ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		sample_valid    <= 1'b1;
		measured_flow   <= flow;
		expiration_time <= te;
		inspired_volume <= vol;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		pending_triggers.push_back(compute_trigger(flow, te, vol));
	endtask

	// Leaves cfg_valid high so that writes may follow back to back.
	task automatic write_reg(logic [itd_pkg::CFG_IDX_W-1:0] idx,
			logic [itd_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			itd_pkg::CFG_SENS:      sens_m = itd_pkg::sens_t'(data[2:0]);
			itd_pkg::CFG_PEEP:      peep_m = data[itd_pkg::PEEP_W-1:0];
			itd_pkg::CFG_ADULT_MIN: adult_min_m = data;
			itd_pkg::CFG_ADULT_MAX: adult_max_m = data;
			itd_pkg::CFG_CHILD_MIN: child_min_m = data;
			itd_pkg::CFG_CHILD_MAX: child_max_m = data;
			default: ;
		endcase
	endtask

	// Writes every register; the spare bits of the narrow ones carry noise, and the
	// unused indexes are written too, which must change nothing.
	task automatic set_config(itd_pkg::sens_t s, int peep, int amin, int amax, int cmin,
			int cmax);
		write_reg(itd_pkg::CFG_SENS, {13'($urandom), s});
		write_reg(itd_pkg::CFG_PEEP, {6'($urandom), 10'(peep)});
		write_reg(itd_pkg::CFG_ADULT_MIN, 16'(amin));
		write_reg(itd_pkg::CFG_ADULT_MAX, 16'(amax));
		write_reg(itd_pkg::CFG_CHILD_MIN, 16'(cmin));
		write_reg(itd_pkg::CFG_CHILD_MAX, 16'(cmax));
		write_reg(CFG_SPARE_A, 16'($urandom));
		write_reg(CFG_SPARE_B, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_triggers.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Reset defaults leave the detector off: even a steep rise gives no trigger.
	task automatic test_reset_state();
		send_sample(-16'sd32768, 16'd0, 16'd0);
		send_sample(16'sd32767, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_sensitivity_levels();
		for (int s = 1; s < 8; s++) begin
			wait_idle();
			set_config(itd_pkg::sens_t'(s), 50, 300, 1000, 300, 600);
			send_sample(rise_flow(20), 16'd100, 16'd1000);
			send_sample(rise_flow(70), 16'd1200, 16'd1000);
		end
	endtask

	// Volumes on and beside the interpolation breakpoints, with the time at, just
	// short of or well above the lockout that results.
	task automatic test_lockout_breakpoints();
		wait_idle();
		set_config(itd_pkg::SENS_L3, 141, 100, 2000, 900, 100);
		send_sample(rise_flow(10), 16'd0, 16'd0);
		send_sample(rise_flow(80), 16'd900, 16'd49);
		send_sample(rise_flow(0), 16'd0, 16'd0);
		send_sample(rise_flow(80), 16'd103, 16'd249);
		send_sample(rise_flow(0), 16'd0, 16'd0);
		send_sample(rise_flow(80), 16'd100, 16'd250);
		send_sample(rise_flow(0), 16'd0, 16'd0);
		send_sample(rise_flow(80), 16'hFFFF, 16'd1901);
	endtask

	task automatic test_random_phases();
		logic signed [itd_pkg::FLOW_W-1:0] flow;
		logic [itd_pkg::TIME_W-1:0]        te;
		logic [itd_pkg::VOL_W-1:0]         vol;
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: set_config(itd_pkg::SENS_L2, 0, 0, 65535, 65535, 0);
				1: set_config(itd_pkg::SENS_L3, 1000, $urandom_range(0, 2500),
					$urandom_range(0, 2500), $urandom_range(0, 2500),
					$urandom_range(0, 2500));
				2: set_config(itd_pkg::SENS_L0P, $urandom_range(0, 1000),
					$urandom_range(0, 2500), $urandom_range(0, 2500),
					$urandom_range(0, 2500), $urandom_range(0, 2500));
				3: set_config(itd_pkg::SENS_L4, 140, 65535, 0, 0, 65535);
				4: set_config(itd_pkg::SENS_L5, 141, $urandom_range(0, 2500),
					$urandom_range(0, 2500), $urandom_range(0, 2500),
					$urandom_range(0, 2500));
				5: set_config(itd_pkg::SENS_L1P, $urandom_range(0, 1000), 300, 1000,
					300, 600);
				6: set_config(itd_pkg::SENS_OTHER, $urandom_range(0, 1000),
					$urandom_range(0, 2500), $urandom_range(0, 2500),
					$urandom_range(0, 2500), $urandom_range(0, 2500));
				default: set_config(itd_pkg::SENS_OFF, $urandom_range(0, 1000),
					$urandom_range(0, 2500), $urandom_range(0, 2500),
					$urandom_range(0, 2500), $urandom_range(0, 2500));
			endcase
			// One phase runs flat out on both sides.
			idle_pct  = (p == 5) ? 0 : 29;
			stall_pct = (p == 5) ? 0 : 29;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 2 && i == ITEMS_PER_PHASE / 2) begin
					sample_valid <= 1'b0;
					do @(posedge clk); while (pending_triggers.size() != 0);
				end
				// Mostly rises and falls around the history, near plausible lockouts;
				// the rest is unrestricted noise over every field.
				if ($urandom_range(99) < 70) begin
					flow = rise_flow(int'($urandom_range(0, 180)) - 90);
					te   = 16'($urandom_range(0, 2500));
					vol  = 16'($urandom_range(0, 2200));
				end else begin
					flow = 16'($urandom);
					te   = 16'($urandom);
					vol  = 16'($urandom);
				end
				send_sample(flow, te, vol);
			end
		end
		idle_pct  = 29;
		stall_pct = 29;
	endtask

	initial begin
		int waited;
		arst_n          = 1'b0;
		sample_valid    = 1'b0;
		measured_flow   = '0;
		expiration_time = '0;
		inspired_volume = '0;
		result_stall    = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = itd_pkg::CFG_SENS;
		cfg_data        = '0;
		error_count     = 0;
		idle_pct        = 29;
		stall_pct       = 29;
		sens_m          = itd_pkg::SENS_OFF;
		peep_m          = 10'd50;
		adult_min_m     = 16'd300;
		adult_max_m     = 16'd1000;
		child_min_m     = 16'd300;
		child_max_m     = 16'd600;
		hist_m          = '0;
		phase_m         = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_sensitivity_levels();
		test_lockout_breakpoints();
		test_random_phases();

		sample_valid <= 1'b0;
		waited = 0;
		while (pending_triggers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (pending_triggers.size() != 0) begin
			$error("trigger_detected: %0d items never arrived", pending_triggers.size());
			error_count++;
		end
		if (error_count == 0)
			$display("inspiration_trigger_detect test passed");
		else
			$display("inspiration_trigger_detect test failed");
		$finish;
	end

endmodule
